/* rtl/swm_pkg.sv */
`timescale 1ns / 1ps
// Package for the sliding-window midprice block.
// Holds the sizes, the controller state codes and the command and status structs.
package swm_pkg;

	localparam int MAX_PERIOD = 64;
	localparam int PTR_W      = $clog2(MAX_PERIOD);
	localparam int CNT_W      = PTR_W + 1;
	localparam int PRICE_W    = 32;
	localparam int MID_W      = PRICE_W + 1;

	localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(14);

	// Controller state codes.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_UPDATE = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic update;
		logic scan_issue;
		logic finish;
	} swm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;
		logic scan_last;
		logic out_free;
	} swm_stat_t;

endpackage

/* rtl/swm_ifs.sv */
`timescale 1ns / 1ps
// Stream interfaces for price bars in and doubled midprices out.
// Depends on swm_pkg for the field widths.
interface swm_bar_if import swm_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      new_series;
	logic signed [PRICE_W-1:0] high_price;
	logic signed [PRICE_W-1:0] low_price;

	modport source (output valid, output new_series, output high_price, output low_price,
		input ready);
	modport sink (input valid, input new_series, input high_price, input low_price,
		output ready);
endinterface

interface swm_mid_if import swm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [MID_W-1:0] mid_doubled;

	modport source (output valid, output mid_doubled, input ready);
	modport sink (input valid, input mid_doubled, output ready);
endinterface

/* rtl/swm_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the sliding-window midprice block.
// Depends on swm_pkg for state codes and the command and status structs.
module swm_ctrl import swm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      bar_valid,
	output logic      bar_ready,
	input  swm_stat_t stat,
	output swm_cmd_t  cmd
);

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		bar_ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				bar_ready = 1'b1;
				if (bar_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = stat.need_scan ? ST_SCAN : ST_RESULT;
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A scan always runs to its last entry before the result is built.
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && !stat.scan_last |=> state_q == ST_SCAN)
		else $error("scan left early");

endmodule

/* rtl/swm_dp.sv */
`timescale 1ns / 1ps
// Datapath for the sliding-window midprice block: bar history memories,
// cached extremes with ages, the rescan pipeline and the output register.
// Depends on swm_pkg.
module swm_dp import swm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  swm_cmd_t                  cmd,
	output swm_stat_t                 stat,
	input  logic                      cfg_we,
	input  logic [CNT_W-1:0]          cfg_wdata,
	input  logic                      bar_new_series,
	input  logic signed [PRICE_W-1:0] bar_high_price,
	input  logic signed [PRICE_W-1:0] bar_low_price,
	output logic                      mid_valid,
	input  logic                      mid_ready,
	output logic signed [MID_W-1:0]   mid_doubled
);

	// Bar history.
	logic signed [PRICE_W-1:0] high_mem [MAX_PERIOD];
	logic signed [PRICE_W-1:0] low_mem  [MAX_PERIOD];

	// Latched request.
	logic                      new_q;
	logic signed [PRICE_W-1:0] hi_q;
	logic signed [PRICE_W-1:0] lo_q;

	// Series and window state.
	logic [CNT_W-1:0]          window_length_q;
	logic [PTR_W-1:0]          write_slot_q;
	logic [CNT_W-1:0]          bars_seen_q;
	logic [PTR_W-1:0]          newest_q;
	logic [CNT_W-1:0]          span_q;
	logic                      emit_q;

	// Cached extremes.
	logic signed [PRICE_W-1:0] best_high_q;
	logic [CNT_W-1:0]          best_high_age_q;
	logic                      best_high_vld_q;
	logic signed [PRICE_W-1:0] best_low_q;
	logic [CNT_W-1:0]          best_low_age_q;
	logic                      best_low_vld_q;

	// Rescan control and read stage.
	logic [PTR_W-1:0]          scan_age_q;
	logic                      first_q;
	logic                      rescan_h_q;
	logic                      rescan_l_q;
	logic                      rd_vld_s1;
	logic                      first_s1;
	logic [PTR_W-1:0]          rd_age_s1;
	logic signed [PRICE_W-1:0] rd_hi_s1;
	logic signed [PRICE_W-1:0] rd_lo_s1;

	// Output register.
	logic                      out_valid_q;
	logic signed [MID_W-1:0]   out_data_q;

	// Update terms for the latched bar.
	logic [PTR_W-1:0] ws;
	logic [CNT_W-1:0] bs;
	logic [CNT_W-1:0] bs_new;
	logic [CNT_W-1:0] len;
	logic [CNT_W-1:0] span;
	logic             hv;
	logic             lv;
	logic [CNT_W-1:0] h_age_inc;
	logic [CNT_W-1:0] l_age_inc;
	logic             h_rescan;
	logic             l_rescan;
	logic [PTR_W-1:0] rd_addr;

	// A new series restarts the slot, the count and the cached extremes.
	always_comb begin
		ws        = new_q ? '0 : write_slot_q;
		bs        = new_q ? '0 : bars_seen_q;
		hv        = !new_q && best_high_vld_q;
		lv        = !new_q && best_low_vld_q;
		bs_new    = (bs < CNT_W'(MAX_PERIOD)) ? bs + 1'b1 : bs;
		if (window_length_q == '0) begin
			len = CNT_W'(1);
		end else if (window_length_q > CNT_W'(MAX_PERIOD)) begin
			len = CNT_W'(MAX_PERIOD);
		end else begin
			len = window_length_q;
		end
		span      = (bs_new < len) ? bs_new : len;
		h_age_inc = best_high_age_q + 1'b1;
		l_age_inc = best_low_age_q + 1'b1;
		h_rescan  = !hv || (h_age_inc >= span);
		l_rescan  = !lv || (l_age_inc >= span);
		rd_addr   = newest_q - scan_age_q;
	end

	assign stat.need_scan = h_rescan || l_rescan;
	assign stat.scan_last = (scan_age_q == '0);
	assign stat.out_free  = !out_valid_q || mid_ready;

	// History memories: one write per bar, one read per scan cycle.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			high_mem[ws] <= hi_q;
			low_mem[ws]  <= lo_q;
		end
		if (cmd.scan_issue) begin
			rd_hi_s1 <= high_mem[rd_addr];
			rd_lo_s1 <= low_mem[rd_addr];
		end
	end

	// Request latch and scan stage payload.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			new_q <= bar_new_series;
			hi_q  <= bar_high_price;
			lo_q  <= bar_low_price;
		end
		if (cmd.scan_issue) begin
			first_s1  <= first_q;
			rd_age_s1 <= scan_age_q;
		end
	end

	// Window bookkeeping, cached extremes and the rescan compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_RESET;
			write_slot_q    <= '0;
			bars_seen_q     <= '0;
			newest_q        <= '0;
			span_q          <= CNT_W'(1);
			emit_q          <= 1'b0;
			best_high_q     <= '0;
			best_high_age_q <= '0;
			best_high_vld_q <= 1'b0;
			best_low_q      <= '0;
			best_low_age_q  <= '0;
			best_low_vld_q  <= 1'b0;
			scan_age_q      <= '0;
			first_q         <= 1'b0;
			rescan_h_q      <= 1'b0;
			rescan_l_q      <= 1'b0;
			rd_vld_s1       <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_issue;
			if (cfg_we) begin
				window_length_q <= cfg_wdata;
				best_high_vld_q <= 1'b0;
				best_low_vld_q  <= 1'b0;
			end
			if (cmd.update) begin
				write_slot_q <= ws + 1'b1;
				bars_seen_q  <= bs_new;
				newest_q     <= ws;
				span_q       <= span;
				emit_q       <= (bs_new >= len);
				scan_age_q   <= PTR_W'(span - 1'b1);
				first_q      <= 1'b1;
				rescan_h_q   <= h_rescan;
				rescan_l_q   <= l_rescan;
				if (h_rescan) begin
					best_high_vld_q <= 1'b0;
				end else if (hi_q >= best_high_q) begin
					best_high_q     <= hi_q;
					best_high_age_q <= '0;
				end else begin
					best_high_age_q <= h_age_inc;
				end
				if (l_rescan) begin
					best_low_vld_q <= 1'b0;
				end else if (lo_q <= best_low_q) begin
					best_low_q     <= lo_q;
					best_low_age_q <= '0;
				end else begin
					best_low_age_q <= l_age_inc;
				end
			end
			if (cmd.scan_issue) begin
				first_q    <= 1'b0;
				scan_age_q <= scan_age_q - 1'b1;
			end
			// Oldest to newest; a strictly better value moves the extreme.
			if (rd_vld_s1) begin
				if (rescan_h_q && (first_s1 || rd_hi_s1 > best_high_q)) begin
					best_high_q     <= rd_hi_s1;
					best_high_age_q <= CNT_W'(rd_age_s1);
					best_high_vld_q <= 1'b1;
				end
				if (rescan_l_q && (first_s1 || rd_lo_s1 < best_low_q)) begin
					best_low_q     <= rd_lo_s1;
					best_low_age_q <= CNT_W'(rd_age_s1);
					best_low_vld_q <= 1'b1;
				end
			end
			if (cmd.update && !h_rescan) begin
				best_high_vld_q <= 1'b1;
			end
			if (cmd.update && !l_rescan) begin
				best_low_vld_q <= 1'b1;
			end
		end
	end

	// Output register holds a result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish && emit_q) begin
			out_valid_q <= 1'b1;
		end else if (mid_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && emit_q) begin
			out_data_q <= MID_W'(best_high_q) + MID_W'(best_low_q);
		end
	end

	assign mid_valid   = out_valid_q;
	assign mid_doubled = out_data_q;

	// The count of bars seen saturates at the history depth.
	a_bars_sat: assert property (@(posedge clk) disable iff (!arst_n)
		bars_seen_q <= CNT_W'(MAX_PERIOD))
		else $error("bars_seen overflow");

	// Both extremes are settled when a bar finishes.
	a_best_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> best_high_vld_q && best_low_vld_q)
		else $error("extreme not settled at finish");

	// Cached positions lie inside the window when a bar finishes.
	a_age_in_win: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> best_high_age_q < span_q && best_low_age_q < span_q)
		else $error("cached extreme outside window");

endmodule

/* rtl/sliding_window_midprice.sv */
`timescale 1ns / 1ps
// Top level of the sliding-window midprice block: controller plus datapath.
// Depends on swm_pkg, swm_ifs, swm_ctrl and swm_dp.
//
//   Channel   Direction  Handshake        Payload
//   bar       in         valid / ready    new_series, high_price, low_price
//   mid       out        valid / ready    mid_doubled (highest high + lowest low)
//   cfg       in         cfg_we           cfg_wdata = window_length
//
// A bar whose cached extremes stay in the window passes through accept, update and
// result. A bar that forces a rescan also passes through scan and drain before result,
// since the history memory gives one entry per cycle to the compare.
// Reset brings window_length to 14 and empties the series; no clearing pass.
// A result waiting in the output register stalls only the finish of the next bar.
module sliding_window_midprice import swm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	swm_bar_if.sink          bar,
	swm_mid_if.source        mid,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	swm_cmd_t  cmd;
	swm_stat_t stat;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.bar_valid (bar.valid),
		.bar_ready (bar.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	swm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.bar_new_series (bar.new_series),
		.bar_high_price (bar.high_price),
		.bar_low_price  (bar.low_price),
		.mid_valid      (mid.valid),
		.mid_ready      (mid.ready),
		.mid_doubled    (mid.mid_doubled)
	);

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the sliding-window midprice block: random and directed price bars.
// Depends on swm_pkg, swm_ifs and sliding_window_midprice from the RTL.
module tb_top;
	import swm_pkg::*;

	// Tracks the window contents and the expected doubled midprices.
	class midprice_board;
		localparam int unsigned AGE_NONE = 32'hFFFF_FFFF;

		logic [CNT_W-1:0]  window_len = WINDOW_RESET;
		longint            high_hist[MAX_PERIOD];
		longint            low_hist[MAX_PERIOD];
		int unsigned       wr_slot = 0;
		int unsigned       seen = 0;
		longint            top_high = 0;
		int unsigned       top_high_age = AGE_NONE;
		longint            bottom_low = 0;
		int unsigned       bottom_low_age = AGE_NONE;
		logic [MID_W-1:0]  mid_q[$];
		int                errors = 0;

		task report(string msg);
			if (errors < 100)
				$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function int unsigned pending();
			return mid_q.size();
		endfunction

		// A new length drops the cached extremes, so the next bar rescans.
		function void set_window(logic [CNT_W-1:0] len);
			window_len = len;
			top_high_age = AGE_NONE;
			bottom_low_age = AGE_NONE;
		endfunction

		function int unsigned slot_at(int unsigned newest, int unsigned age);
			return (newest + MAX_PERIOD - age) % MAX_PERIOD;
		endfunction

		// Updates the window with one accepted request and queues its result.
		function void note_bar(bit fresh, logic signed [PRICE_W-1:0] hi,
				logic signed [PRICE_W-1:0] lo);
			int unsigned len;
			int unsigned span;
			int unsigned newest;
			int unsigned a;
			longint v;
			len = (window_len == 0) ? 1 : (window_len > MAX_PERIOD) ? MAX_PERIOD : window_len;
			if (fresh) begin
				wr_slot = 0;
				seen = 0;
				top_high_age = AGE_NONE;
				bottom_low_age = AGE_NONE;
			end
			newest = wr_slot;
			high_hist[newest] = longint'(hi);
			low_hist[newest] = longint'(lo);
			wr_slot = (newest + 1) % MAX_PERIOD;
			if (seen < MAX_PERIOD)
				seen++;
			if (top_high_age != AGE_NONE)
				top_high_age++;
			if (bottom_low_age != AGE_NONE)
				bottom_low_age++;
			span = (seen < len) ? seen : len;

			// Highest high: rescan oldest to newest when the cached one aged out.
			if (top_high_age >= span) begin
				top_high_age = span - 1;
				top_high = high_hist[slot_at(newest, span - 1)];
				for (a = span - 1; a > 0; a--) begin
					v = high_hist[slot_at(newest, a - 1)];
					if (v > top_high) begin
						top_high = v;
						top_high_age = a - 1;
					end
				end
			end else if (longint'(hi) >= top_high) begin
				top_high = longint'(hi);
				top_high_age = 0;
			end

			// Lowest low, the same way.
			if (bottom_low_age >= span) begin
				bottom_low_age = span - 1;
				bottom_low = low_hist[slot_at(newest, span - 1)];
				for (a = span - 1; a > 0; a--) begin
					v = low_hist[slot_at(newest, a - 1)];
					if (v < bottom_low) begin
						bottom_low = v;
						bottom_low_age = a - 1;
					end
				end
			end else if (longint'(lo) <= bottom_low) begin
				bottom_low = longint'(lo);
				bottom_low_age = 0;
			end

			if (seen >= len)
				mid_q.push_back(MID_W'(top_high + bottom_low));
		endfunction

		task check_mid(logic [MID_W-1:0] got);
			logic [MID_W-1:0] want;
			if (mid_q.size() == 0) begin
				report($sformatf("result %0d with none expected", $signed(got)));
			end else begin
				want = mid_q.pop_front();
				if (got !== want)
					report($sformatf("mid_doubled got %0d expected %0d",
						$signed(got), $signed(want)));
			end
		endtask

		task check_leftover();
			if (mid_q.size() != 0)
				report($sformatf("%0d results never arrived", mid_q.size()));
		endtask
	endclass

	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AT       = 250;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	swm_bar_if bar_ch();
	swm_mid_if mid_ch();

	midprice_board board = new();

	int                        bars_sent = 0;
	int                        mids_seen = 0;
	bit                        calm = 1'b0;
	logic signed [PRICE_W-1:0] level;

	sliding_window_midprice i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bar       (bar_ch),
		.mid       (mid_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Offers one request, at times with a random gap first, and waits for acceptance.
	task send_bar(bit fresh, logic signed [PRICE_W-1:0] hi, logic signed [PRICE_W-1:0] lo);
		if (!calm && $urandom_range(99) < 28) begin
			bar_ch.valid <= 1'b0;
			bar_ch.new_series <= 1'($urandom);
			bar_ch.high_price <= $urandom;
			bar_ch.low_price <= $urandom;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		bar_ch.valid <= 1'b1;
		bar_ch.new_series <= fresh;
		bar_ch.high_price <= hi;
		bar_ch.low_price <= lo;
		do @(posedge clk); while (!bar_ch.ready);
		board.note_bar(fresh, hi, lo);
		bars_sent++;
		calm = (bars_sent >= 700 && bars_sent < 1000);
	endtask

	// Writes the window length once the block has gone quiet.
	task write_window(logic [CNT_W-1:0] len);
		bar_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_window(len);
	endtask

	// Mostly plausible bars around a drifting level, some ties, some noise.
	task random_bars(int count, int restart_odds);
		bit fresh;
		int pick;
		logic signed [PRICE_W-1:0] hi;
		logic signed [PRICE_W-1:0] lo;
		logic signed [PRICE_W-1:0] corners[4];
		corners = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1};
		for (int i = 0; i < count; i++) begin
			fresh = ($urandom_range(restart_odds - 1) == 0);
			if (fresh)
				level = $urandom;
			pick = $urandom_range(99);
			if (pick < 55) begin
				level = level + $signed(32'($urandom_range(2000))) - 1000;
				hi = level + $urandom_range(500);
				lo = level - $urandom_range(500);
			end else if (pick < 75) begin
				hi = level + $urandom_range(3);
				lo = level - $urandom_range(3);
			end else if (pick < 90) begin
				hi = $urandom;
				lo = $urandom;
			end else begin
				hi = corners[$urandom_range(3)];
				lo = corners[$urandom_range(3)];
			end
			send_bar(fresh, hi, lo);
		end
	endtask

	// Result side: random stalls and one long hold-off that backs up the block.
	initial begin
		bit held;
		held = 1'b0;
		mid_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (mid_ch.valid && mid_ch.ready) begin
				board.check_mid(mid_ch.mid_doubled);
				mids_seen++;
			end
			if (!held && mids_seen >= HOLD_AT) begin
				held = 1'b1;
				mid_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mid_ch.ready <= calm || ($urandom_range(99) >= 28);
		end
	end

	// Main sequence: reset, directed bars, then random phases over several lengths.
	initial begin
		int phase_len[12];
		int phase_items[12];
		int cycles;
		phase_len = '{14, 0, 64, 2, 127, 5, 1, 65, 33, 3, 20, 7};
		phase_items = '{160, 150, 170, 150, 140, 150, 150, 140, 150, 150, 150, 150};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		bar_ch.valid = 1'b0;
		bar_ch.new_series = 1'b0;
		bar_ch.high_price = '0;
		bar_ch.low_price = '0;
		level = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Length one: every bar gives a result, including the output extremes.
		write_window(1);
		send_bar(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_bar(1'b0, 32'sh8000_0000, 32'sh8000_0000);
		send_bar(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_bar(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_bar(1'b0, 32'sh0, 32'sh0);
		send_bar(1'b0, -32'sh1, 32'sh1);
		send_bar(1'b1, 32'sh5, 32'sh5);

		// Length three: warm-up, ties, extremes leaving the window, restart.
		write_window(3);
		send_bar(1'b1, 32'sd100, 32'sd50);
		send_bar(1'b0, 32'sd100, 32'sd50);
		send_bar(1'b0, 32'sd90, 32'sd60);
		send_bar(1'b0, 32'sd80, 32'sd70);
		send_bar(1'b0, 32'sd70, 32'sd40);
		send_bar(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_bar(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_bar(1'b1, 32'sd1, 32'sd1);
		send_bar(1'b0, 32'sd2, 32'sd0);
		send_bar(1'b0, 32'sd3, -32'sd1);
		send_bar(1'b0, 32'sd3, -32'sd1);

		for (int p = 0; p < 12; p++) begin
			write_window(phase_len[p]);
			random_bars(phase_items[p], (phase_len[p] >= 33) ? 90 : 30);
		end
		bar_ch.valid <= 1'b0;

		// Drain, then give a stray result time to show up.
		cycles = 0;
		while (board.pending() != 0 && cycles < 20000) begin
			@(posedge clk);
			cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		board.check_leftover();
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
